@@ design/dense_layer_relu_assert.svh @@
// ----------------------------------------------------------------------------
// dense_layer_relu_assert.svh
// Assertion macros for the dense layer block.
// ----------------------------------------------------------------------------
`ifndef DENSE_LAYER_RELU_ASSERT_SVH
`define DENSE_LAYER_RELU_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define DLR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dense_layer_relu: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DLR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dense_layer_relu: check failed");

`else

`define DLR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DLR_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

@@ design/dlr_pkg.sv @@
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types, codes and helpers of the dense layer block.
// ----------------------------------------------------------------------------
package dlr_pkg;

    // Sizes of the layer and of the arithmetic.
    localparam int MAX_INPUTS  = 64;
    localparam int MAX_OUTPUTS = 64;
    localparam int FRAC_BITS   = 8;
    localparam int DATA_W      = 16;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int ACC_W       = 40;
    localparam int IN_IDX_W    = $clog2(MAX_INPUTS);
    localparam int OUT_IDX_W   = $clog2(MAX_OUTPUTS);
    localparam int CNT_W       = 7;
    localparam int POS_W       = 12;

    // Saturation bounds in accumulator width.
    localparam logic signed [ACC_W-1:0] VAL_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] VAL_MIN = ACC_W'(-32768);

    // Request type codes.
    localparam logic [1:0] REQ_WEIGHT  = 2'd0;
    localparam logic [1:0] REQ_BIAS    = 2'd1;
    localparam logic [1:0] REQ_ELEMENT = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IN_COUNT  = 2'd0;
    localparam logic [1:0] CFG_OUT_COUNT = 2'd1;
    localparam logic [1:0] CFG_RELU      = 2'd2;

    // Input request payload.
    typedef struct packed {
        logic [1:0]              req_type;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] data_value;
        logic                    vector_end;
    } dlr_in_t;

    // Output request payload.
    typedef struct packed {
        logic [OUT_IDX_W-1:0]    neuron_index;
        logic signed [DATA_W-1:0] neuron_value;
        logic                    final_neuron;
    } dlr_out_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    // Operand strobe toward the MAC unit.
    typedef struct packed {
        logic valid;
        logic first;
    } mac_ctrl_t;

    // Status back from the MAC unit.
    typedef struct packed {
        logic idle;
    } mac_stat_t;

    // A count of zero acts as one, and counts above the maximum act as it.
    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c,
                                                      input logic [CNT_W-1:0] max_c);
        logic [CNT_W-1:0] r;
        if (c == '0)
            r = CNT_W'(1);
        else if (c > max_c)
            r = max_c;
        else
            r = c;
        return r;
    endfunction

endpackage

@@ design/dlr_mac.sv @@
// ----------------------------------------------------------------------------
// dlr_mac
// Shared multiply-accumulate unit with shift, saturation and ReLU.
// ----------------------------------------------------------------------------
module dlr_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  dlr_pkg::mac_ctrl_t                ctrl,
    input  logic signed [dlr_pkg::DATA_W-1:0] x_data,
    input  logic signed [dlr_pkg::DATA_W-1:0] w_data,
    input  logic signed [dlr_pkg::DATA_W-1:0] bias_data,
    input  logic                              relu_en,
    output dlr_pkg::mac_stat_t                stat,
    output logic signed [dlr_pkg::DATA_W-1:0] value
);
    import dlr_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_first_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  bias_ext;
    logic signed [ACC_W-1:0]  shifted;

    // Multiplier stage: one signed 16x16 product per cycle.
    always_ff @(posedge clk)
    begin
        prod_reg <= x_data * w_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg   <= 1'b0;
            prod_first_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg   <= ctrl.valid;
            prod_first_reg <= ctrl.valid & ctrl.first;
        end
    end

    // The bias enters the sum aligned to the product's fraction.
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign bias_ext = {{(ACC_W-DATA_W-FRAC_BITS){bias_data[DATA_W-1]}}, bias_data,
                       {FRAC_BITS{1'b0}}};

    // Accumulator: restarts from the bias on the first product of a neuron.
    always_comb
    begin
        if (!prod_vld_reg)
            acc_next = acc_reg;
        else if (prod_first_reg)
            acc_next = bias_ext + prod_ext;
        else
            acc_next = acc_reg + prod_ext;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Floor shift, saturation to 16 bits, then optional ReLU.
    assign shifted = acc_reg >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > VAL_MAX)
            value = VAL_MAX[DATA_W-1:0];
        else if (shifted < VAL_MIN)
            value = VAL_MIN[DATA_W-1:0];
        else
            value = shifted[DATA_W-1:0];
        if (relu_en && value[DATA_W-1])
            value = '0;
    end

    assign stat.idle = !ctrl.valid && !prod_vld_reg;

endmodule

@@ design/dense_layer_relu.sv @@
// ----------------------------------------------------------------------------
// dense_layer_relu
// Fully connected layer in signed Q8.8 with saturation and optional ReLU.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload     handshake
//  in        request    dlr_in_t    in_valid / in_stall
//  out       result     dlr_out_t   out_valid / out_stall
//  cfg       write      cfg_data    cfg_we, cfg_index
//
// Loads and elements without the end mark are taken while in_stall is low.
// A vector's processing time is set by the single shared MAC and the one read
// port of the weight memory, and by output stalls.
// in_stall stays high from the end-marked element until the final neuron is taken.
// Reset clears control and configuration only; the stores are undefined until
// written and need no clearing pass.
//
module dense_layer_relu (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  dlr_pkg::dlr_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output dlr_pkg::dlr_out_t             out_data,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [dlr_pkg::CNT_W-1:0]     cfg_data
);
    import dlr_pkg::*;

    // Stores.
    logic [DATA_W-1:0] weight_mem [MAX_INPUTS*MAX_OUTPUTS];
    logic [DATA_W-1:0] bias_mem   [MAX_OUTPUTS];
    logic [DATA_W-1:0] input_mem  [MAX_INPUTS];

    // Configuration.
    logic [CNT_W-1:0] in_count_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             relu_en_reg;
    logic [CNT_W-1:0] ni;
    logic [CNT_W-1:0] no;

    // Sequencer.
    state_t               state_reg;
    state_t               state_next;
    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     i_next;
    logic [OUT_IDX_W-1:0] j_reg;
    logic [OUT_IDX_W-1:0] j_next;
    logic                 rd_vld_reg;
    logic                 rd_first_reg;
    logic                 issue;
    logic                 in_accept;
    logic                 out_accept;
    logic                 start;
    logic                 calc_done;
    logic                 is_final;

    // Read data and output register.
    logic signed [DATA_W-1:0] x_rd_reg;
    logic signed [DATA_W-1:0] w_rd_reg;
    logic signed [DATA_W-1:0] bias_rd_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    dlr_out_t                 out_data_reg;
    dlr_out_t                 out_data_next;

    // MAC interface.
    mac_ctrl_t                mac_ctrl;
    mac_stat_t                mac_stat;
    logic signed [DATA_W-1:0] mac_value;

    assign ni = clamp_count(in_count_reg, CNT_W'(MAX_INPUTS));
    assign no = clamp_count(out_count_reg, CNT_W'(MAX_OUTPUTS));

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_accept = out_valid_reg && !out_stall;
    assign start      = in_accept && (in_data.req_type == REQ_ELEMENT) && in_data.vector_end;
    assign issue      = (state_reg == ST_CALC) && (i_reg != ni);
    assign calc_done  = (state_reg == ST_CALC) && (i_reg == ni) && !rd_vld_reg
                        && mac_stat.idle;
    assign is_final   = ({1'b0, j_reg} + CNT_W'(1)) == no;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_count_reg  <= CNT_W'(64);
            out_count_reg <= CNT_W'(64);
            relu_en_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_IN_COUNT:  in_count_reg  <= cfg_data;
                CFG_OUT_COUNT: out_count_reg <= cfg_data;
                CFG_RELU:      relu_en_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // Weight memory: one write port for loads, one read port for the MAC.
    always_ff @(posedge clk)
    begin
        if (in_accept && in_data.req_type == REQ_WEIGHT)
            weight_mem[in_data.position] <= in_data.data_value;
        w_rd_reg <= weight_mem[{i_reg[IN_IDX_W-1:0], j_reg}];
    end

    // Bias memory: positions beyond the store are dropped.
    always_ff @(posedge clk)
    begin
        if (in_accept && in_data.req_type == REQ_BIAS
            && in_data.position[POS_W-1:OUT_IDX_W] == '0)
            bias_mem[in_data.position[OUT_IDX_W-1:0]] <= in_data.data_value;
        bias_rd_reg <= bias_mem[j_reg];
    end

    // Input vector memory: positions beyond the store are dropped.
    always_ff @(posedge clk)
    begin
        if (in_accept && in_data.req_type == REQ_ELEMENT
            && in_data.position[POS_W-1:IN_IDX_W] == '0)
            input_mem[in_data.position[IN_IDX_W-1:0]] <= in_data.data_value;
        x_rd_reg <= input_mem[i_reg[IN_IDX_W-1:0]];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (calc_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_accept)
                    state_next = is_final ? ST_IDLE : ST_CALC;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Counters and output register.
    always_comb
    begin
        i_next         = i_reg;
        j_next         = j_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    i_next = '0;
                    j_next = '0;
                end
            end
            ST_CALC:
            begin
                if (issue)
                    i_next = i_reg + CNT_W'(1);
                if (calc_done)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.neuron_index = j_reg;
                    out_data_next.neuron_value = mac_value;
                    out_data_next.final_neuron = is_final;
                end
            end
            ST_EMIT:
            begin
                if (out_accept)
                begin
                    out_valid_next = 1'b0;
                    i_next         = '0;
                    j_next         = j_reg + OUT_IDX_W'(1);
                end
            end
            default:
                out_valid_next = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            rd_vld_reg    <= issue;
            rd_first_reg  <= issue && (i_reg == '0);
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // Shared MAC.
    assign mac_ctrl.valid = rd_vld_reg;
    assign mac_ctrl.first = rd_first_reg;

    dlr_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (mac_ctrl),
        .x_data    (x_rd_reg),
        .w_data    (w_rd_reg),
        .bias_data (bias_rd_reg),
        .relu_en   (relu_en_reg),
        .stat      (mac_stat),
        .value     (mac_value)
    );

    // Checks.
    `include "dense_layer_relu_assert.svh"

    `DLR_ASSERT_IMP(a_out_only_in_emit, clk, rst_n, out_valid_reg, state_reg == ST_EMIT)
    `DLR_ASSERT_IMP(a_mac_idle_when_idle, clk, rst_n, state_reg == ST_IDLE, mac_stat.idle)
    `DLR_ASSERT_IMP(a_issue_bounded, clk, rst_n, state_reg == ST_CALC, i_reg <= ni)
    `DLR_ASSERT_NXT(a_final_ends_vector, clk, rst_n, out_accept && out_data_reg.final_neuron,
                    state_reg == ST_IDLE)

endmodule
